[src/lz77te_pkg.sv]
// Shared types, sizes and address helpers for the LZ77 token encoder.
// Depends on nothing; imported by the RAM-backed core and its checker.
package lz77te_pkg;

	localparam int WinSize = 32;
	localparam int AddrW   = $clog2(WinSize);
	localparam int CntW    = $clog2(WinSize + 1);

	typedef logic [AddrW-1:0] pos_t;
	typedef logic [CntW-1:0]  cnt_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       is_last;
	} byte_word_t;

	typedef struct packed {
		logic [5:0] distance;
		logic [5:0] match_length;
		logic [7:0] literal;
		logic       final_token;
	} token_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND,
		ST_SCAN,
		ST_MISS,
		ST_HIT,
		ST_PREF,
		ST_WAIT,
		ST_EXT,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_LIT
	} enc_state_t;

	localparam logic [AddrW:0] WinSizeX = (AddrW + 1)'(WinSize);
	localparam pos_t           LastPos  = pos_t'(WinSize - 1);
	localparam cnt_t           FullCnt  = cnt_t'(WinSize);

	// Window position (0 = newest) to physical RAM address.
	function automatic pos_t phys_addr(input pos_t head, input pos_t pos);
		logic [AddrW:0] d;
		d = {1'b0, head} - {1'b0, pos};
		if (d[AddrW]) begin
			d = d + WinSizeX;
		end
		return d[AddrW-1:0];
	endfunction

	function automatic pos_t next_head(input pos_t head);
		return (head == LastPos) ? '0 : pos_t'(head + 1'b1);
	endfunction

endpackage

[src/lz77te_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module lz77te_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/lz77_token_encoder_core.sv]
// LZ77 token encoder: an accepted byte is searched for in the window, one filled position
// per step (up to 32), oldest first; the next byte is taken only in the idle or wait state.
// Each byte that extends a match passes the hit, prefetch (where the match can still grow),
// wait and extend states. Closing a token writes the matched bytes back, a read and a write
// each, then the literal. This order comes from the single read port of the RAM.
// arst_n low, and every final token, empty the window through its fill count.
module lz77_token_encoder_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     byte_valid,
	output logic                     byte_stall,
	input  lz77te_pkg::byte_word_t   byte_word,
	output logic                     token_valid,
	input  logic                     token_stall,
	output lz77te_pkg::token_word_t  token_word
);
	import lz77te_pkg::*;

	enc_state_t  state_q, state_d;
	pos_t        head_q;
	cnt_t        fill_q;
	logic [7:0]  b_q;
	logic        last_q;
	pos_t        pos_q;
	pos_t        start_q;
	cnt_t        cnt_q;
	cnt_t        left_q;
	logic [7:0]  expect_q;
	logic        can_ext_q;
	logic        out_valid_q;
	token_word_t out_q;

	logic        ram_we;
	pos_t        ram_waddr, ram_raddr;
	logic [7:0]  ram_wdata, ram_rdata;
	pos_t        rd_pos;

	logic        out_free, take, hit, push, wipe, scan_load, scan_step;
	logic        ext_inc, pref_load, expect_clr, copy_begin, copy_adv, emit;
	pos_t        hit_pos;
	token_word_t emit_word;

	logic [AddrW:0] dist_full;
	logic           ext_ok;
	pos_t           ext_pos;
	logic           ext_valid, src_ok;

	assign out_free  = !out_valid_q || !token_stall;
	assign dist_full = {1'b0, start_q} + 1'b1;
	assign ext_ok    = cnt_q <= cnt_t'(start_q);
	assign ext_pos   = start_q - pos_t'(cnt_q);
	assign ext_valid = cnt_t'(ext_pos) < fill_q;
	assign src_ok    = cnt_t'(start_q) < fill_q;

	assign ram_waddr = next_head(head_q);
	assign ram_raddr = phys_addr(head_q, rd_pos);

	lz77te_ram #(
		.WIDTH (8),
		.DEPTH (WinSize)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ram_we     = 1'b0;
		ram_wdata  = b_q;
		rd_pos     = '0;
		take       = 1'b0;
		hit        = 1'b0;
		hit_pos    = '0;
		push       = 1'b0;
		wipe       = 1'b0;
		scan_load  = 1'b0;
		scan_step  = 1'b0;
		ext_inc    = 1'b0;
		pref_load  = 1'b0;
		expect_clr = 1'b0;
		copy_begin = 1'b0;
		copy_adv   = 1'b0;
		emit       = 1'b0;
		emit_word  = '0;
		case (state_q)
			ST_IDLE: begin
				if (byte_valid) begin
					take    = 1'b1;
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				// unwritten positions read as zero, the oldest of them is the last one
				if (b_q == 8'd0 && fill_q != FullCnt) begin
					hit     = 1'b1;
					hit_pos = LastPos;
					state_d = ST_HIT;
				end else if (fill_q == '0) begin
					state_d = ST_MISS;
				end else begin
					rd_pos    = pos_t'(fill_q - 1'b1);
					scan_load = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (ram_rdata == b_q) begin
					hit     = 1'b1;
					hit_pos = pos_q;
					state_d = ST_HIT;
				end else if (pos_q == '0) begin
					state_d = ST_MISS;
				end else begin
					rd_pos    = pos_q - 1'b1;
					scan_step = 1'b1;
				end
			end
			ST_MISS: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_word = '{distance: 6'd0, match_length: 6'd0,
						literal: b_q, final_token: last_q};
					if (last_q) begin
						wipe = 1'b1;
					end else begin
						ram_we = 1'b1;
						push   = 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_HIT: begin
				if (last_q) begin
					if (out_free) begin
						emit      = 1'b1;
						emit_word = '{distance: 6'(dist_full), match_length: 6'(cnt_q),
							literal: 8'd0, final_token: 1'b1};
						wipe      = 1'b1;
						state_d   = ST_IDLE;
					end
				end else if (ext_ok) begin
					rd_pos  = ext_pos;
					state_d = ST_PREF;
				end else begin
					expect_clr = 1'b1;
					state_d    = ST_WAIT;
				end
			end
			ST_PREF: begin
				pref_load = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (byte_valid) begin
					take    = 1'b1;
					state_d = ST_EXT;
				end
			end
			ST_EXT: begin
				if (can_ext_q && b_q == expect_q) begin
					ext_inc = 1'b1;
					state_d = ST_HIT;
				end else if (out_free) begin
					emit      = 1'b1;
					emit_word = '{distance: 6'(dist_full), match_length: 6'(cnt_q),
						literal: b_q, final_token: last_q};
					if (last_q) begin
						wipe    = 1'b1;
						state_d = ST_IDLE;
					end else begin
						copy_begin = 1'b1;
						state_d    = ST_COPY_RD;
					end
				end
			end
			ST_COPY_RD: begin
				// the next source byte always sits at the match start as the head advances
				rd_pos  = start_q;
				state_d = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				ram_we    = 1'b1;
				ram_wdata = src_ok ? ram_rdata : 8'd0;
				push      = 1'b1;
				copy_adv  = 1'b1;
				state_d   = (left_q == cnt_t'(1)) ? ST_LIT : ST_COPY_RD;
			end
			ST_LIT: begin
				ram_we  = 1'b1;
				push    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// window bookkeeping and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			can_ext_q   <= 1'b0;
		end else begin
			if (wipe) begin
				head_q <= '0;
				fill_q <= '0;
			end else if (push) begin
				head_q <= next_head(head_q);
				if (fill_q != FullCnt) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!token_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pref_load) begin
				can_ext_q <= 1'b1;
			end else if (expect_clr) begin
				can_ext_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			b_q    <= byte_word.data_byte;
			last_q <= byte_word.is_last;
		end
		if (scan_load || scan_step) begin
			pos_q <= rd_pos;
		end
		if (hit) begin
			start_q <= hit_pos;
			cnt_q   <= cnt_t'(1);
		end else if (ext_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end
		if (pref_load) begin
			expect_q <= ext_valid ? ram_rdata : 8'd0;
		end
		if (copy_begin) begin
			left_q <= cnt_q;
		end else if (copy_adv) begin
			left_q <= left_q - 1'b1;
		end
		if (emit) begin
			out_q <= emit_word;
		end
	end

	assign byte_stall  = !(state_q == ST_IDLE || state_q == ST_WAIT);
	assign token_valid = out_valid_q;
	assign token_word  = out_q;

endmodule

[src/lz77te_checker.sv]
// Port-level checks for the LZ77 token encoder core, bound into lz77_token_encoder_core.
// Depends on lz77te_pkg for the channel word types.
module lz77te_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     byte_valid,
	input logic                     byte_stall,
	input lz77te_pkg::byte_word_t   byte_word,
	input logic                     token_valid,
	input logic                     token_stall,
	input lz77te_pkg::token_word_t  token_word
);
	import lz77te_pkg::*;

	// hold a stalled token
	a_token_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid)
		else $error("token dropped while stalled");

	a_token_stable: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> $stable(token_word))
		else $error("stalled token word changed");

	// every accepted byte is worked on before the next one is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_stall |=> byte_stall)
		else $error("byte taken while previous byte still in work");

	// a fresh token only comes out of processing, never straight from the input side
	a_token_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(token_valid) |-> $past(byte_stall))
		else $error("token appeared without processing");

endmodule

bind lz77_token_encoder_core lz77te_checker u_lz77te_checker (.*);

[tb/lz77_token_encoder_core_tb.sv]
// Self-checking testbench for lz77_token_encoder_core: byte messages in, LZ77 tokens out.
// Tokens are predicted per accepted word and compared against the block's output stream.
// Depends on lz77te_pkg for the word types and the window size.
module lz77_token_encoder_core_tb;
	import lz77te_pkg::*;

	typedef logic [7:0] byte_q_t[$];

	localparam int QuietLimit    = 2000;
	localparam int HoldOffCycles = 300;
	localparam int DrainCycles   = 100;
	localparam int RandomItems   = 750;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	byte_word_t  byte_word = '0;
	logic        token_valid;
	logic        token_stall = 1'b0;
	token_word_t token_word;

	// Encoder shadow: window position 0 is the newest byte.
	logic [7:0]  hist_bytes [WinSize];
	bit          in_match;
	int          match_pos;
	int          match_len;

	token_word_t expected_tokens[$];
	int          mismatches = 0;
	int          items_sent = 0;
	int          quiet_cycles = 0;
	int          sender_gap_max = 10;
	int          recv_gap_max = 10;
	int          recv_wait = 0;
	bit          hold_off = 1'b0;

	lz77_token_encoder_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_word   (byte_word),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_word  (token_word)
	);

	always #2 clk = ~clk;

	function automatic void clear_encoder();
		foreach (hist_bytes[i]) hist_bytes[i] = 8'd0;
		in_match  = 1'b0;
		match_pos = 0;
		match_len = 0;
	endfunction

	function automatic void push_hist(input logic [7:0] b);
		for (int i = WinSize - 1; i > 0; i--) hist_bytes[i] = hist_bytes[i-1];
		hist_bytes[0] = b;
	endfunction

	function automatic void encode_byte(input byte_word_t w, output bit has_tok,
			output token_word_t tok);
		int         found;
		int         n;
		bit         extend;
		logic [7:0] run [WinSize];
		has_tok = 1'b1;
		tok     = '0;
		if (!in_match) begin
			found = -1;
			// oldest position holding the byte wins
			for (int i = WinSize - 1; i >= 0; i--) begin
				if (found < 0 && hist_bytes[i] == w.data_byte) found = i;
			end
			if (found < 0) begin
				tok = '{6'd0, 6'd0, w.data_byte, w.is_last};
				if (w.is_last) clear_encoder();
				else push_hist(w.data_byte);
			end else begin
				in_match  = 1'b1;
				match_pos = found;
				match_len = 1;
				if (w.is_last) begin
					tok = '{6'(found + 1), 6'd1, 8'd0, 1'b1};
					clear_encoder();
				end else begin
					has_tok = 1'b0;
				end
			end
		end else begin
			extend = 1'b0;
			// a match can not grow past the newest entry
			if (match_len <= match_pos) extend = (hist_bytes[match_pos - match_len] == w.data_byte);
			if (extend) begin
				match_len++;
				if (w.is_last) begin
					tok = '{6'(match_pos + 1), 6'(match_len), 8'd0, 1'b1};
					clear_encoder();
				end else begin
					has_tok = 1'b0;
				end
			end else begin
				tok = '{6'(match_pos + 1), 6'(match_len), w.data_byte, w.is_last};
				if (w.is_last) begin
					clear_encoder();
				end else begin
					n = (match_len < match_pos + 1) ? match_len : match_pos + 1;
					for (int k = 0; k < n; k++) run[k] = hist_bytes[match_pos - k];
					for (int k = 0; k < n; k++) push_hist(run[k]);
					push_hist(w.data_byte);
					in_match  = 1'b0;
					match_pos = 0;
					match_len = 0;
				end
			end
		end
	endfunction

	// Called at a rising edge; returns at the edge that accepts the word.
	task automatic send_byte(input logic [7:0] b, input bit last);
		int          gap;
		bit          has_tok;
		token_word_t tok;
		gap = $urandom_range(0, sender_gap_max);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_word  <= '{b, last};
		do @(posedge clk); while (byte_stall !== 1'b0);
		encode_byte('{b, last}, has_tok, tok);
		if (has_tok) expected_tokens = {expected_tokens, tok};
		items_sent++;
	endtask

	task automatic send_message(input byte_q_t msg);
		foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
	endtask

	function automatic byte_q_t run_of_distinct(input int count);
		byte_q_t q;
		int      base;
		base = $urandom_range(0, 254);
		for (int k = 0; k < count; k++) q = {q, 8'(1 + (base + k) % 255)};
		return q;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Token sink: random stall per word plus the long hold-off.
	always @(posedge clk) begin
		token_word_t want;
		if (arst_n && token_valid === 1'b1 && token_stall === 1'b0) begin
			if (expected_tokens.size() == 0) begin
				$display("%0t: unexpected token, expected none, got %p", $time, token_word);
				mismatches++;
			end else begin
				want = expected_tokens.pop_front();
				compare_field("distance", 8'(want.distance), 8'(token_word.distance));
				compare_field("match_length", 8'(want.match_length), 8'(token_word.match_length));
				compare_field("literal", want.literal, token_word.literal);
				compare_field("final_token", 8'(want.final_token), 8'(token_word.final_token));
			end
			recv_wait = $urandom_range(0, recv_gap_max);
		end else if (recv_wait > 0) begin
			recv_wait--;
		end
		token_stall <= hold_off || (recv_wait > 0);
	end

	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (token_valid && !token_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= QuietLimit) begin
			$display("lz77_token_encoder_core_tb failed");
			$finish;
		end
	end

	task automatic test_single_literal();
		send_message('{8'h41});
	endtask

	task automatic test_repeat_match();
		send_message('{8'h41, 8'h42, 8'h43, 8'h41, 8'h42, 8'h43, 8'h44});
	endtask

	// match at the newest entry: an equal byte still becomes the literal
	task automatic test_newest_entry_limit();
		send_message('{8'h5a, 8'h5a, 8'h5a, 8'h5a});
	endtask

	task automatic test_end_inside_match();
		send_message('{8'h58, 8'h59, 8'h58});
		send_message('{8'h58, 8'h59, 8'h58, 8'h59});
	endtask

	task automatic test_byte_extremes();
		send_message('{8'h01, 8'hff, 8'h01});
	endtask

	// Hold the sink off while the source keeps offering literal-only words.
	task automatic test_backpressure();
		sender_gap_max = 0;
		fork
			begin
				hold_off <= 1'b1;
				repeat (HoldOffCycles) @(posedge clk);
				hold_off <= 1'b0;
			end
		join_none
		send_message(run_of_distinct(40));
		sender_gap_max = 10;
	endtask

	task automatic test_random_messages();
		byte_q_t    msg;
		byte_q_t    chunk;
		int         kind;
		int         len;
		int         base;
		int         span;
		logic [7:0] extra;
		while (items_sent < RandomItems) begin
			msg = {};
			sender_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
			recv_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 10;
			kind = $urandom_range(0, 19);
			if (kind == 0) begin
				// fill the window, then replay it for a full-length match
				chunk = run_of_distinct(WinSize);
				msg   = {chunk, chunk};
				extra = ($urandom_range(0, 1) == 0) ? chunk[0] : 8'($urandom_range(1, 255));
				msg   = {msg, extra};
			end else if (kind < 4) begin
				len = $urandom_range(1, 20);
				for (int i = 0; i < len; i++) msg = {msg, 8'($urandom_range(1, 255))};
			end else if (kind < 10) begin
				chunk = {};
				len = $urandom_range(1, 12);
				for (int i = 0; i < len; i++) chunk = {chunk, 8'($urandom_range(1, 255))};
				repeat ($urandom_range(2, 4)) begin
					foreach (chunk[i]) begin
						if ($urandom_range(0, 15) == 0) msg = {msg, 8'($urandom_range(1, 255))};
						else msg = {msg, chunk[i]};
					end
				end
				// drop a random tail so messages also end mid-match
				repeat ($urandom_range(0, len - 1)) msg.delete(msg.size() - 1);
			end else begin
				span = $urandom_range(2, 6);
				base = $urandom_range(1, 256 - span);
				len  = $urandom_range(1, 40);
				for (int i = 0; i < len; i++) msg = {msg, 8'(base + $urandom_range(0, span - 1))};
			end
			send_message(msg);
		end
	endtask

	initial begin
		clear_encoder();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_literal();
		test_repeat_match();
		test_newest_entry_limit();
		test_end_inside_match();
		test_byte_extremes();
		test_backpressure();
		test_random_messages();
		byte_valid <= 1'b0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("lz77_token_encoder_core_tb passed");
		end else begin
			$display("lz77_token_encoder_core_tb failed");
		end
		$finish;
	end

endmodule
